>>> src/bf3_pkg.sv
// package for the 3x3 box filter: widths, register codes, queue entry type
// and the divide-by-nine constants
// no dependencies
package bf3_pkg;

  // line buffer depth and derived widths
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int W_W       = $clog2(MAX_WIDTH + 1);

  // field and register widths
  localparam int PIX_W      = 8;
  localparam int WIDTH_CFG_W = 11;
  localparam int HGT_W      = 12;
  localparam int ROW_W      = HGT_W + 1;
  localparam int CFG_DATA_W = 12;
  localparam int MIN_DIM    = 3;

  // reset values of the configuration registers
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0]       HEIGHT_RST = 12'd480;

  // sum of nine pixels and floor(sum / 9) as multiply and shift
  localparam int SUM_W = PIX_W + 4;
  localparam int DIV9_SHIFT = 16;
  localparam int DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int PROD_W = SUM_W + DIV9_MUL_W;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // classification of one item, decided at the front
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } bf3_tag_t;

  // one queue entry
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    bf3_tag_t         tag;
  } bf3_item_t;

endpackage

>>> src/bf3_front.sv
// front part of the 3x3 box filter: configuration registers, input and
// output position counters, classification of each accepted item
// depends on bf3_pkg
module bf3_front import bf3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  is_padding_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output bf3_item_t             item_o
);

  logic [WIDTH_CFG_W-1:0] width_q;
  logic [HGT_W-1:0]       height_q;
  logic [W_W-1:0]         w_use;
  logic [HGT_W-1:0]       h_use;
  logic [COL_W-1:0]       in_col_q, in_col_d;
  logic [ROW_W-1:0]       in_row_q, in_row_d;
  logic [COL_W-1:0]       out_col_q, out_col_d;
  logic [HGT_W-1:0]       out_row_q, out_row_d;
  logic [W_W-1:0]         in_col_inc;
  logic [W_W-1:0]         out_col_inc;
  logic                   accept;
  logic                   restart;
  bf3_tag_t               tag;

  // clamp the registers to the supported range
  always_comb begin
    if (width_q < WIDTH_CFG_W'(MIN_DIM)) begin
      w_use = W_W'(MIN_DIM);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_use = W_W'(MAX_WIDTH);
    end else begin
      w_use = W_W'(width_q);
    end
    if (height_q < HGT_W'(MIN_DIM)) begin
      h_use = HGT_W'(MIN_DIM);
    end else begin
      h_use = height_q;
    end
  end

  // handshake
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // classification by position
  always_comb begin
    tag.emit   = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
    tag.border = (out_row_q == '0) || (out_row_q >= h_use - HGT_W'(1)) ||
                 (out_col_q == '0) || (W_W'(out_col_q) >= w_use - W_W'(1));
    tag.last   = (out_row_q == h_use - HGT_W'(1)) && (W_W'(out_col_q) == w_use - W_W'(1));
  end

  assign push_o       = accept;
  assign item_o.pixel = is_padding_i ? '0 : pixel_in_i;
  assign item_o.col   = in_col_q;
  assign item_o.tag   = tag;

  // next positions
  always_comb begin
    in_col_inc  = W_W'(in_col_q) + W_W'(1);
    out_col_inc = W_W'(out_col_q) + W_W'(1);
    restart     = in_row_q >= (ROW_W'(h_use) + ROW_W'(1));
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (tag.emit) begin
      if (out_col_inc >= w_use) begin
        out_col_d = '0;
        out_row_d = out_row_q + HGT_W'(1);
      end else begin
        out_col_d = COL_W'(out_col_inc);
      end
    end
    if (in_col_inc >= w_use) begin
      in_col_d = '0;
      in_row_d = in_row_q + ROW_W'(1);
    end else begin
      in_col_d = COL_W'(in_col_inc);
    end
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  // configuration registers and counters; a register write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (accept) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

>>> src/bf3_queue.sv
// short queue of classified items between the front and the back
// depends on bf3_pkg
module bf3_queue import bf3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bf3_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output bf3_item_t item_o,
  output logic      empty_o
);

  bf3_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // fill count stays in range and follows the transfers
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue fill count did not follow a push");

endmodule

>>> src/bf3_back.sv
// back part of the 3x3 box filter: two line buffers in one memory, the
// 3x3 window, the nine-pixel sum, divide by nine and the output register
// depends on bf3_pkg
module bf3_back import bf3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bf3_item_t        item_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             is_last_of_frame_o
);

  // line memory entry: older line in the upper byte, newer in the lower
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic             adv;
  logic             a_valid_q;
  bf3_item_t        a_item_q;
  logic             b_valid_q;
  bf3_tag_t         b_tag_q;
  logic [PIX_W-1:0] win_q [3][3];
  logic [SUM_W-1:0] win_sum;
  logic             c_valid_q;
  logic             c_border_q;
  logic             c_last_q;
  logic [SUM_W-1:0] c_sum_q;
  logic [PIX_W-1:0] c_center_q;
  logic [PROD_W-1:0] prod;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pixel_q;
  logic             out_last_q;

  // the whole back moves when the output register is free or drained
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  // line memory: read at the popped column, write back one stage later
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= line_mem[item_i.col];
    end
    if (adv && a_valid_q) begin
      line_mem[a_item_q.col] <= {rd_q[PIX_W-1:0], a_item_q.pixel};
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_item_q    <= item_i;
      b_tag_q     <= a_item_q.tag;
      c_border_q  <= b_tag_q.border;
      c_last_q    <= b_tag_q.last;
      c_sum_q     <= win_sum;
      c_center_q  <= win_q[1][1];
      out_pixel_q <= c_border_q ? c_center_q : prod[DIV9_SHIFT+PIX_W-1:DIV9_SHIFT];
      out_last_q  <= c_last_q;
    end
  end

  // window shift with the new column from the line memory and the input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (adv && a_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_q[2*PIX_W-1:PIX_W];
      win_q[1][2] <= rd_q[PIX_W-1:0];
      win_q[2][2] <= a_item_q.pixel;
    end
  end

  // nine-pixel sum
  always_comb begin
    win_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_sum = win_sum + SUM_W'(win_q[r][c]);
      end
    end
  end

  // floor(sum / 9) by reciprocal multiply
  assign prod = PROD_W'(c_sum_q) * PROD_W'(DIV9_MUL);

  // stage valid bits; only emitting items reach the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= !empty_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q && b_tag_q.emit;
      out_valid_q <= c_valid_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pixel_out_o        = out_pixel_q;
  assign is_last_of_frame_o = out_last_q;

endmodule

>>> src/box_filter_3x3_top.sv
// path: the item that completes a window passes stage a, the window registers,
// stage c and the output register; results lag inputs by width+1 items
// throughput: one item per cycle while the output is not stalled, set by one
// line memory read and one write-back per cycle
// reset: width 640, height 480, counters and window cleared; line memory keeps
// its contents and needs no clearing pass
// depends on bf3_pkg, bf3_front, bf3_queue, bf3_back
module box_filter_3x3_top import bf3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  input  logic                  is_padding_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic                  is_last_of_frame_o
);

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  bf3_item_t push_item;
  bf3_item_t head_item;

  // accept and classify
  bf3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .is_padding_i (is_padding_i),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  // decoupling queue
  bf3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  // line buffers, window and filter
  bf3_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (head_item),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pixel_out_o        (pixel_out_o),
    .is_last_of_frame_o (is_last_of_frame_o)
  );

endmodule
